/* rtl/mcd_pkg.sv */
// ----------------------------------------------------------------------------
// mcd_pkg
// shared types and constants for the moravec corner detector
// ----------------------------------------------------------------------------
package mcd_pkg;

    localparam int unsigned REG_IDX_W = 2;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_WIDTH     = 2'd0,
        REG_HEIGHT    = 2'd1,
        REG_RADIUS    = 2'd2,
        REG_THRESHOLD = 2'd3
    } t_reg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PLAN,
        ST_CALC,
        ST_EMIT,
        ST_NEXT
    } t_state;

    // sequencer to window engine
    typedef struct packed {
        logic        start;
        logic [12:0] pos_x;
        logic [16:0] pos_y;
    } t_eval_req;

    // window engine back to sequencer
    typedef struct packed {
        logic        done;
        logic [21:0] score;
    } t_eval_rsp;

endpackage

/* rtl/mcd_window.sv */
// ----------------------------------------------------------------------------
// mcd_window
// line store and the squared-difference window engine
// ----------------------------------------------------------------------------
module mcd_window #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 4096,
    parameter int MAX_RADIUS = 3
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_wr_en,
    input  logic [$clog2(2*MAX_RADIUS+2)-1:0] i_wr_slot,
    input  logic [$clog2(MAX_WIDTH)-1:0]      i_wr_col,
    input  logic [7:0]                        i_wr_data,
    input  logic [12:0]                       i_w,
    input  logic [16:0]                       i_h,
    input  logic [2:0]                        i_r,
    input  mcd_pkg::t_eval_req                i_req,
    output mcd_pkg::t_eval_rsp                o_rsp
);
    localparam int ROWS   = 2*MAX_RADIUS+2;
    localparam int SLOT_W = $clog2(ROWS);
    localparam int COL_W  = $clog2(MAX_WIDTH);

    logic [7:0] mem [ROWS*MAX_WIDTH];

    // window walk: per pixel c, then up to 4 neighbors (r,d,dr,dl)
    logic [3:0]  r_m, r_k;     // offsets 0..2r
    logic [2:0]  r_ph;         // 0 centre, 1..4 neighbors
    logic        r_busy;
    logic [12:0] r_x;
    logic [16:0] r_y;
    logic [21:0] r_s [4];
    logic [7:0]  r_c;
    logic        r_rd_v;
    logic [2:0]  r_rd_ph;
    logic [1:0]  r_rd_dir;
    logic        r_rd_use;
    logic [7:0]  r_q;
    logic        r_fin;
    logic        r_done;
    logic [21:0] r_score;

    logic signed [17:0] py, px, ny, nx;
    logic               use_n;
    logic [1:0]         dir;
    logic [SLOT_W-1:0]  rd_slot;
    logic [COL_W-1:0]   rd_col;

    always_comb begin
        py  = $signed({1'b0, r_y}) - $signed({14'd0, i_r}) + $signed({14'd0, r_k});
        px  = $signed({5'b0, r_x}) - $signed({15'd0, i_r}) + $signed({14'd0, r_m});
        ny  = py;
        nx  = px;
        dir = 2'd0;
        use_n = 1'b1;
        case (r_ph)
            3'd1: begin
                nx = px + 18'sd1; dir = 2'd0;
                use_n = nx < $signed({5'b0, i_w});
            end
            3'd2: begin
                ny = py + 18'sd1; dir = 2'd1;
                use_n = ny < $signed({1'b0, i_h});
            end
            3'd3: begin
                ny = py + 18'sd1; nx = px + 18'sd1; dir = 2'd2;
                use_n = (ny < $signed({1'b0, i_h})) && (nx < $signed({5'b0, i_w}));
            end
            3'd4: begin
                ny = py + 18'sd1; nx = px - 18'sd1; dir = 2'd3;
                use_n = (ny < $signed({1'b0, i_h})) && (nx >= 18'sd0);
            end
            default: ;
        endcase
        rd_slot = SLOT_W'(ny % ROWS);
        rd_col  = nx[COL_W-1:0];
    end

    always_ff @(i_clk) begin end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[{i_wr_slot, i_wr_col}] <= i_wr_data;
        end
        r_q <= mem[{rd_slot, rd_col}];
    end

    logic [8:0]  d;
    logic [16:0] sq;
    logic [21:0] m0, m1;
    always_comb begin
        d  = (r_q > r_c) ? {1'b0, r_q} - {1'b0, r_c} : {1'b0, r_c} - {1'b0, r_q};
        sq = 17'(d * d);
        m0 = (r_s[0] < r_s[1]) ? r_s[0] : r_s[1];
        m1 = (r_s[2] < r_s[3]) ? r_s[2] : r_s[3];
    end

    logic [3:0] side;
    assign side = {i_r, 1'b0};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_rd_v <= 1'b0;
            r_fin  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            r_rd_v <= r_busy;
            r_rd_ph  <= r_ph;
            r_rd_dir <= dir;
            r_rd_use <= use_n;
            if (r_rd_v) begin
                if (r_rd_ph == 3'd0) begin
                    r_c <= r_q;
                end else if (r_rd_use) begin
                    r_s[r_rd_dir] <= r_s[r_rd_dir] + 22'(sq);
                end
            end
            r_fin <= 1'b0;
            if (r_fin && !r_rd_v) begin
                r_done  <= 1'b1;
                r_score <= (m0 < m1) ? m0 : m1;
            end
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_x  <= i_req.pos_x;
                r_y  <= i_req.pos_y;
                r_m  <= '0;
                r_k  <= '0;
                r_ph <= '0;
                for (int i = 0; i < 4; i++) r_s[i] <= '0;
            end else if (r_busy) begin
                if (r_ph != 3'd4) begin
                    r_ph <= r_ph + 3'd1;
                end else begin
                    r_ph <= '0;
                    if (r_m != side) begin
                        r_m <= r_m + 4'd1;
                    end else begin
                        r_m <= '0;
                        if (r_k != side) begin
                            r_k <= r_k + 4'd1;
                        end else begin
                            r_busy <= 1'b0;
                            r_fin  <= 1'b1;
                        end
                    end
                end
            end
            if (r_fin && r_rd_v) r_fin <= 1'b1;
        end
    end

    assign o_rsp.done  = r_done;
    assign o_rsp.score = r_score;

`ifndef SYNTHESIS
    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> !i_req.start) else $error("window engine restarted while busy");
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> !r_done) else $error("done held");
    a_idle_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> !r_done) else $error("done while busy");
`endif

endmodule

/* rtl/moravec_corner_detect.sv */
// ----------------------------------------------------------------------------
// moravec_corner_detect
// streaming moravec corner detector over a line store memory
// ----------------------------------------------------------------------------
// pixels enter in raster order, one beat each; every interior position is
// scored on the beat that brings its last needed pixel (zero, one, two or four
// result beats per pixel). the score walks the (2r+1)^2 window through one
// memory read port, five reads per window pixel (centre plus four neighbors),
// and a pixel is not accepted until all its results are taken. the line store
// keeps 2*MAX_RADIUS+2 rows and needs no clearing pass.
module moravec_corner_detect #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 4096,
    parameter int MAX_RADIUS = 3
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // pixel
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // pos_x[9:0] pos_y[21:10] score[43:22] is_corner[44]
    output logic        m_axis_tlast,   // last_of_run
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [21:0] i_cfg_data
);
    localparam int ROWS   = 2*MAX_RADIUS+2;
    localparam int SLOT_W = $clog2(ROWS);
    localparam int COL_W  = $clog2(MAX_WIDTH);

    logic [10:0] r_w_reg;
    logic [12:0] r_h_reg;
    logic [1:0]  r_r_reg;
    logic [21:0] r_thr;
    logic [12:0] r_col;
    logic [16:0] r_row;

    // effective geometry
    logic [12:0] w;
    logic [16:0] h;
    logic [2:0]  r;
    always_comb begin
        w = (r_w_reg == 0) ? 13'd1 : ({2'b0, r_w_reg} > 13'(MAX_WIDTH) ? 13'(MAX_WIDTH)
                                                                       : {2'b0, r_w_reg});
        h = (r_h_reg == 0) ? 17'd1 : ({4'b0, r_h_reg} > 17'(MAX_HEIGHT) ? 17'(MAX_HEIGHT)
                                                                        : {4'b0, r_h_reg});
        r = ({1'b0, r_r_reg} > 3'(MAX_RADIUS)) ? 3'(MAX_RADIUS) : {1'b0, r_r_reg};
    end

    mcd_pkg::t_state r_st, n_st;
    logic [17:0] r_ys [2];
    logic [17:0] r_xs [2];
    logic        r_ny2, r_nx2;
    logic        r_iy, r_ix;   // current candidate indexes
    logic        r_found;
    logic [12:0] r_cx;
    logic [16:0] r_cy;
    logic [21:0] r_score;
    logic        r_has_more;
    logic        r_outv;

    mcd_pkg::t_eval_req req;
    mcd_pkg::t_eval_rsp rsp;

    logic acc;
    assign s_axis_tready = (r_st == mcd_pkg::ST_IDLE);
    assign acc = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready = (r_st == mcd_pkg::ST_IDLE);

    // candidate check
    logic signed [17:0] cy_s, cx_s;
    logic               cand_ok;
    always_comb begin
        cy_s = $signed(r_ys[r_iy]);
        cx_s = $signed(r_xs[r_ix]);
        cand_ok = (cy_s >= $signed({15'd0, r})) &&
                  (cy_s <= $signed({1'b0, h}) - 18'sd1 - $signed({15'd0, r})) &&
                  (cx_s >= $signed({15'd0, r})) &&
                  (cx_s <= $signed({5'b0, w}) - 18'sd1 - $signed({15'd0, r}));
    end

    // next candidate after (r_iy, r_ix)
    logic n_end;
    logic n_iy, n_ix;
    always_comb begin
        n_iy = r_iy; n_ix = r_ix; n_end = 1'b0;
        if (r_nx2 && !r_ix) begin
            n_ix = 1'b1;
        end else if (r_ny2 && !r_iy) begin
            n_iy = 1'b1; n_ix = 1'b0;
        end else begin
            n_end = 1'b1;
        end
    end

    // does any valid candidate follow the current one
    logic later_ok;
    always_comb begin
        later_ok = 1'b0;
        for (int a = 0; a < 2; a++) begin
            for (int b = 0; b < 2; b++) begin
                if (((a == 1 && r_ny2) || a == 0) && ((b == 1 && r_nx2) || b == 0) &&
                    ((2*a + b) > (2*int'(r_iy) + int'(r_ix))) &&
                    ($signed(r_ys[a]) >= $signed({15'd0, r})) &&
                    ($signed(r_ys[a]) <= $signed({1'b0, h}) - 18'sd1 - $signed({15'd0, r})) &&
                    ($signed(r_xs[b]) >= $signed({15'd0, r})) &&
                    ($signed(r_xs[b]) <= $signed({5'b0, w}) - 18'sd1 - $signed({15'd0, r})))
                    later_ok = 1'b1;
            end
        end
    end

    always_comb begin
        n_st = r_st;
        req.start = 1'b0;
        req.pos_x = r_xs[r_ix][12:0];
        req.pos_y = r_ys[r_iy][16:0];
        unique case (r_st)
            mcd_pkg::ST_IDLE: if (acc) n_st = mcd_pkg::ST_PLAN;
            mcd_pkg::ST_PLAN: begin
                if (cand_ok) begin
                    req.start = 1'b1;
                    n_st = mcd_pkg::ST_CALC;
                end else if (n_end) begin
                    n_st = mcd_pkg::ST_NEXT;
                end
            end
            mcd_pkg::ST_CALC: if (rsp.done) n_st = mcd_pkg::ST_EMIT;
            mcd_pkg::ST_EMIT: begin
                if (m_axis_tready) n_st = n_end ? mcd_pkg::ST_NEXT : mcd_pkg::ST_PLAN;
            end
            mcd_pkg::ST_NEXT: n_st = mcd_pkg::ST_IDLE;
            default: n_st = mcd_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_st <= mcd_pkg::ST_IDLE;
        else          r_st <= n_st;
    end

    // pixel position and write into line store
    logic [12:0] pcx;
    logic [16:0] pcy;
    always_comb begin
        pcx = r_col;
        pcy = r_row;
        if (pcx >= w) begin pcx = '0; pcy = pcy + 17'd1; end
        if (pcy >= h) pcy = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w_reg <= 11'd640;
            r_h_reg <= 13'd480;
            r_r_reg <= 2'd1;
            r_thr   <= 22'd500;
            r_col   <= '0;
            r_row   <= '0;
            r_iy    <= 1'b0;
            r_ix    <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (mcd_pkg::t_reg_idx'(i_cfg_index))
                    mcd_pkg::REG_WIDTH:  begin r_w_reg <= i_cfg_data[10:0];
                        r_col <= '0; r_row <= '0; end
                    mcd_pkg::REG_HEIGHT: begin r_h_reg <= i_cfg_data[12:0];
                        r_col <= '0; r_row <= '0; end
                    mcd_pkg::REG_RADIUS: begin r_r_reg <= i_cfg_data[1:0];
                        r_col <= '0; r_row <= '0; end
                    default: r_thr <= i_cfg_data;
                endcase
            end
            if (acc) begin
                r_cx <= pcx;
                r_cy <= pcy;
                r_iy <= 1'b0;
                r_ix <= 1'b0;
                if (pcy < h - 17'd1) begin
                    r_ys[0] <= $signed({1'b0, pcy}) - $signed({15'd0, r}) - 18'sd1;
                    r_ny2   <= 1'b0;
                end else begin
                    r_ys[0] <= $signed({1'b0, h}) - $signed({15'd0, r}) - 18'sd2;
                    r_ys[1] <= $signed({1'b0, h}) - $signed({15'd0, r}) - 18'sd1;
                    r_ny2   <= 1'b1;
                end
                if (pcx < w - 13'd1) begin
                    r_xs[0] <= $signed({5'b0, pcx}) - $signed({15'd0, r}) - 18'sd1;
                    r_nx2   <= 1'b0;
                end else begin
                    r_xs[0] <= $signed({5'b0, w}) - $signed({15'd0, r}) - 18'sd2;
                    r_xs[1] <= $signed({5'b0, w}) - $signed({15'd0, r}) - 18'sd1;
                    r_nx2   <= 1'b1;
                end
            end
            if (r_st == mcd_pkg::ST_PLAN && !cand_ok && !n_end) begin
                r_iy <= n_iy; r_ix <= n_ix;
            end
            if (r_st == mcd_pkg::ST_CALC && rsp.done) begin
                r_score    <= rsp.score;
                r_has_more <= later_ok;
            end
            if (r_st == mcd_pkg::ST_EMIT && m_axis_tready && !n_end) begin
                r_iy <= n_iy; r_ix <= n_ix;
            end
            if (r_st == mcd_pkg::ST_NEXT) begin
                if (r_cx + 13'd1 >= w) begin
                    r_col <= '0;
                    r_row <= (r_cy + 17'd1 >= h) ? 17'd0 : r_cy + 17'd1;
                end else begin
                    r_col <= r_cx + 13'd1;
                    r_row <= r_cy;
                end
            end
        end
    end

    mcd_window #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_HEIGHT(MAX_HEIGHT),
        .MAX_RADIUS(MAX_RADIUS)
    ) u_window (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wr_en  (acc),
        .i_wr_slot(SLOT_W'(pcy % ROWS)),
        .i_wr_col (pcx[COL_W-1:0]),
        .i_wr_data(s_axis_tdata),
        .i_w      (w),
        .i_h      (h),
        .i_r      (r),
        .i_req    (req),
        .o_rsp    (rsp)
    );

    assign r_outv        = (r_st == mcd_pkg::ST_EMIT);
    assign m_axis_tvalid = r_outv;
    assign m_axis_tlast  = !r_has_more;
    assign m_axis_tdata  = {3'b0, (r_score > r_thr), r_score, r_ys[r_iy][11:0],
                            r_xs[r_ix][9:0]};

`ifndef SYNTHESIS
    a_no_in_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !s_axis_tready) else $error("input taken during emit");
    a_emit_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> cand_ok) else $error("emitting non-interior position");
    a_plan_after: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc |=> r_st == mcd_pkg::ST_PLAN) else $error("accept did not start plan");
`endif

endmodule
